// File: rtl/websocket_frame_deframer_top_defines.svh
// Assertion macros for the WebSocket frame deframer.
// Used by websocket_frame_deframer_top.sv; needs clk_i and rst_ni in scope.
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, checked at every clock edge out of reset.
`define WSFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every clock edge out of reset.
`define WSFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/wsfd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; used by wsfd_parser and websocket_frame_deframer_top.
package wsfd_pkg;

  // Parser phase, one-hot.
  typedef enum logic [4:0] {
    PH_FIRST   = 5'b00001,
    PH_SECOND  = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_KEY     = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_e;

  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES    = 4'd2;
  localparam logic [3:0] EXT64_BYTES    = 4'd8;
  localparam logic [3:0] HDR_BASE_BYTES = 4'd2;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef struct packed {
    logic        kind;
    logic        fin;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] payload_length;
    logic [3:0]  header_bytes;
    logic [7:0]  data_byte;
    logic        end_of_frame;
  } result_t;

endpackage

// File: rtl/wsfd_parser.sv
// Frame header decoder and payload unmasking state for the deframer.
// Depends on wsfd_pkg.
module wsfd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  output logic                res_vld_o,
  output wsfd_pkg::result_t   res_o,
  output wsfd_pkg::phase_e    phase_o
);

  wsfd_pkg::phase_e phase_q, phase_d;
  logic [3:0]  ext_q, ext_d;
  logic [3:0]  hcnt_q, hcnt_d;
  logic        fin_q, fin_d;
  logic [3:0]  op_q, op_d;
  logic        mask_q, mask_d;
  logic [63:0] len_q, len_d;
  logic [63:0] rem_q, rem_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  kidx_q, kidx_d;

  always_comb begin
    logic       len_done;
    logic       hdr_done;
    logic       kind;
    logic       eof;
    logic [7:0] data;
    logic [6:0] code;
    phase_d  = phase_q;
    ext_d    = ext_q;
    hcnt_d   = hcnt_q;
    fin_d    = fin_q;
    op_d     = op_q;
    mask_d   = mask_q;
    len_d    = len_q;
    rem_d    = rem_q;
    key_d    = key_q;
    kidx_d   = kidx_q;
    len_done = 1'b0;
    hdr_done = 1'b0;
    kind     = wsfd_pkg::KIND_HEADER;
    eof      = 1'b0;
    data     = 8'd0;
    res_vld_o = 1'b0;
    code     = byte_i[6:0];
    case (phase_q)
      wsfd_pkg::PH_SECOND: begin
        mask_d = byte_i[7];
        hcnt_d = wsfd_pkg::HDR_BASE_BYTES;
        if (code == wsfd_pkg::LEN_CODE_EXT16) begin
          ext_d   = wsfd_pkg::EXT16_BYTES;
          len_d   = '0;
          phase_d = wsfd_pkg::PH_EXTLEN;
        end else if (code == wsfd_pkg::LEN_CODE_EXT64) begin
          ext_d   = wsfd_pkg::EXT64_BYTES;
          len_d   = '0;
          phase_d = wsfd_pkg::PH_EXTLEN;
        end else begin
          len_d    = {57'd0, code};
          len_done = 1'b1;
        end
      end
      wsfd_pkg::PH_EXTLEN: begin
        len_d  = {len_q[55:0], byte_i};
        hcnt_d = hcnt_q + 4'd1;
        ext_d  = ext_q - 4'd1;
        len_done = (ext_d == 4'd0);
      end
      wsfd_pkg::PH_KEY: begin
        key_d    = {key_q[23:0], byte_i};
        hcnt_d   = hcnt_q + 4'd1;
        kidx_d   = kidx_q + 2'd1;
        hdr_done = (kidx_d == 2'd0);
      end
      wsfd_pkg::PH_PAYLOAD: begin
        // Key bytes are used most significant first.
        data      = byte_i ^ key_q[{~kidx_q, 3'b000} +: 8];
        kidx_d    = kidx_q + 2'd1;
        rem_d     = rem_q - 64'd1;
        // The last byte is the one taken with a single byte left.
        eof       = (rem_q == 64'd1);
        kind      = wsfd_pkg::KIND_PAYLOAD;
        res_vld_o = 1'b1;
        if (eof) begin
          phase_d = wsfd_pkg::PH_FIRST;
        end
      end
      default: begin
        fin_d   = byte_i[7];
        op_d    = byte_i[3:0];
        hcnt_d  = 4'd1;
        phase_d = wsfd_pkg::PH_SECOND;
      end
    endcase

    if (len_done) begin
      key_d = '0;
      if (mask_d) begin
        phase_d = wsfd_pkg::PH_KEY;
        kidx_d  = 2'd0;
      end else begin
        hdr_done = 1'b1;
      end
    end

    if (hdr_done) begin
      rem_d     = len_d;
      kidx_d    = 2'd0;
      eof       = (len_d == '0);
      res_vld_o = 1'b1;
      phase_d   = eof ? wsfd_pkg::PH_FIRST : wsfd_pkg::PH_PAYLOAD;
    end

    res_o.kind           = kind;
    res_o.fin            = fin_d;
    res_o.opcode         = op_d;
    res_o.masked         = mask_d;
    res_o.payload_length = len_d;
    res_o.header_bytes   = hcnt_d;
    res_o.data_byte      = data;
    res_o.end_of_frame   = eof;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wsfd_pkg::PH_FIRST;
      ext_q   <= '0;
      hcnt_q  <= '0;
      fin_q   <= 1'b0;
      op_q    <= '0;
      mask_q  <= 1'b0;
      len_q   <= '0;
      rem_q   <= '0;
      key_q   <= '0;
      kidx_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      ext_q   <= ext_d;
      hcnt_q  <= hcnt_d;
      fin_q   <= fin_d;
      op_q    <= op_d;
      mask_q  <= mask_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
      key_q   <= key_d;
      kidx_q  <= kidx_d;
    end
  end

  assign phase_o = phase_q;

endmodule

// File: rtl/websocket_frame_deframer_top.sv
// WebSocket frame deframer (RFC 6455 frame parser), top level.
// Depends on wsfd_pkg, wsfd_parser and websocket_frame_deframer_top_defines.svh.
//
// Usage:
//   The input channel carries one raw byte of the frame stream per request
//   (in_valid_i / in_stall_o / in_byte_i). Header bytes produce no output
//   until the header is complete; then one header request (kind 0) leaves
//   on the output channel, followed by one unmasked payload byte (kind 1)
//   per input byte. The last request of a frame has end_of_frame_o set; a
//   frame with an empty payload ends on its header request.
//   A byte accepted into the input register is decoded from there by the
//   parser, and its result is loaded into the output register, from which
//   the receiver takes it. Throughput is one byte per cycle while the
//   receiver does not stall, limited by the single pass through the parser
//   between the two registers.
//   When the receiver stalls, the output register holds its request. Header
//   bytes that produce no result keep flowing; the first byte that would
//   produce a result waits in the input register, and the input stalls.
//   Reset clears the valid flags of both registers and returns the parser
//   to waiting for the first header byte of a frame.
`include "websocket_frame_deframer_top_defines.svh"

module websocket_frame_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic        fin_o,
  output logic [3:0]  opcode_o,
  output logic        masked_o,
  output logic [63:0] payload_length_o,
  output logic [3:0]  header_bytes_o,
  output logic [7:0]  data_byte_o,
  output logic        end_of_frame_o
);

  // Input register.
  logic       in_vld_q;
  logic [7:0] in_byte_q;

  // Output register.
  logic              out_vld_q;
  wsfd_pkg::result_t out_q;

  // Parser interface.
  logic              res_vld;
  wsfd_pkg::result_t res;
  wsfd_pkg::phase_e  phase;

  logic in_accept;
  logic out_take;
  logic adv;
  logic out_load;

  // Phase and result decodes used by the checks below.
  logic res_payload;
  logic at_payload;
  logic at_first;

  // The held byte advances when it yields no result, or when the output
  // register is empty or being drained in this cycle.
  assign out_take   = out_vld_q && !out_stall_i;
  assign adv        = in_vld_q && (!res_vld || !out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = adv && res_vld;

  assign res_payload = (res.kind == wsfd_pkg::KIND_PAYLOAD);
  assign at_payload  = (phase == wsfd_pkg::PH_PAYLOAD);
  assign at_first    = (phase == wsfd_pkg::PH_FIRST);

  wsfd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (adv),
    .byte_i    (in_byte_q),
    .res_vld_o (res_vld),
    .res_o     (res),
    .phase_o   (phase)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= in_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign kind_o           = out_q.kind;
  assign fin_o            = out_q.fin;
  assign opcode_o         = out_q.opcode;
  assign masked_o         = out_q.masked;
  assign payload_length_o = out_q.payload_length;
  assign header_bytes_o   = out_q.header_bytes;
  assign data_byte_o      = out_q.data_byte;
  assign end_of_frame_o   = out_q.end_of_frame;

  // A byte held back by a full, stalled output register must stay put.
  `WSFD_ASSERT_NEXT(a_hold_input, in_stall_o, in_vld_q && $stable(in_byte_q), "input byte lost")

  // Payload results come only from the payload phase.
  `WSFD_ASSERT_NOW(a_payload_phase, res_vld && res_payload, at_payload, "stray payload result")

  // A frame's last result returns the parser to the first header byte.
  `WSFD_ASSERT_NEXT(a_eof_restart, out_load && res.end_of_frame, at_first, "no frame restart")

endmodule
